// File: hdl/vev_pkg.sv
package vev_pkg;

    localparam logic [2:0] REQ_STEP    = 3'd0;
    localparam logic [2:0] REQ_WRITE   = 3'd1;
    localparam logic [2:0] REQ_TRIGGER = 3'd2;
    localparam logic [2:0] REQ_STOP    = 3'd3;
    localparam logic [2:0] REQ_INIT    = 3'd4;

    localparam logic [31:0] STOPPED_TIME  = 32'hFFFF_FFFF;
    localparam logic [31:0] GRID_OFFSET   = 32'h0000_1000;
    localparam logic [31:0] GRID_MASK     = 32'h0000_7FFF;
    localparam logic [31:0] IDLE_INTERVAL = 32'd8 << 15;
    localparam logic [7:0]  CH1_ENV_INIT  = 8'hF3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  reg_value;
        logic [31:0] cycle_count;
        logic        is_channel1;
    } t_req;

    typedef struct packed {
        logic [3:0]  volume;
        logic [31:0] next_event_time;
        logic        dac_off;
    } t_res;

    typedef struct packed {
        logic [3:0]  volume_level;
        logic [31:0] event_time;
        logic [7:0]  envelope_reg;
    } t_state;

endpackage

// File: hdl/vev_if.sv
interface vev_req_if;
    logic          valid;
    logic          ready;
    vev_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vev_res_if;
    logic          valid;
    logic          ready;
    vev_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/vev_calc.sv
module vev_calc (
    input  vev_pkg::t_state i_state,
    input  vev_pkg::t_req   i_req,
    output vev_pkg::t_state o_state
);

    logic [2:0]  w_period;
    logic        w_dir_up;
    logic [4:0]  w_step_vol;
    logic [3:0]  w_wr_vol;
    logic [3:0]  w_trig_p;
    logic [31:0] w_grid;

    assign w_period = i_state.envelope_reg[2:0];
    assign w_dir_up = i_state.envelope_reg[3];

    // five bits so an underflow or overflow shows in the top bit
    assign w_step_vol = w_dir_up ? ({1'b0, i_state.volume_level} + 5'd1)
                                 : ({1'b0, i_state.volume_level} - 5'd1);

    // align down to the grid set by GRID_OFFSET and GRID_MASK
    assign w_grid = i_req.cycle_count
                  - ((i_req.cycle_count - vev_pkg::GRID_OFFSET) & vev_pkg::GRID_MASK);

    always_comb begin
        w_trig_p = (w_period == 3'd0) ? 4'd8 : {1'b0, w_period};
        if (i_req.cycle_count[14:12] == 3'd0) begin
            w_trig_p = w_trig_p + 4'd1;
        end
    end

    // zombie-mode volume change on a register write
    always_comb begin
        w_wr_vol = i_state.volume_level;
        if (w_period == 3'd0 && i_state.event_time != vev_pkg::STOPPED_TIME) begin
            w_wr_vol = w_wr_vol + 4'd1;
        end else if (!w_dir_up) begin
            w_wr_vol = w_wr_vol + 4'd2;
        end
        if (w_dir_up != i_req.reg_value[3]) begin
            w_wr_vol = 4'd0 - w_wr_vol;
        end
    end

    always_comb begin
        o_state = i_state;
        case (i_req.req_type)
            vev_pkg::REQ_STEP: begin
                if (w_period == 3'd0) begin
                    o_state.event_time = i_state.event_time + vev_pkg::IDLE_INTERVAL;
                end else if (w_step_vol[4]) begin
                    o_state.event_time = vev_pkg::STOPPED_TIME;
                end else begin
                    o_state.volume_level = w_step_vol[3:0];
                    o_state.event_time   = i_state.event_time + {14'd0, w_period, 15'd0};
                end
            end
            vev_pkg::REQ_WRITE: begin
                o_state.volume_level = w_wr_vol;
                o_state.envelope_reg = i_req.reg_value;
            end
            vev_pkg::REQ_TRIGGER: begin
                o_state.event_time   = w_grid + {13'd0, w_trig_p, 15'd0};
                o_state.volume_level = i_state.envelope_reg[7:4];
            end
            vev_pkg::REQ_STOP: begin
                o_state.event_time = vev_pkg::STOPPED_TIME;
            end
            vev_pkg::REQ_INIT: begin
                o_state.volume_level = 4'd0;
                if (i_req.is_channel1) begin
                    o_state.envelope_reg = vev_pkg::CH1_ENV_INIT;
                    o_state.event_time   = vev_pkg::STOPPED_TIME;
                end else begin
                    o_state.envelope_reg = 8'd0;
                    o_state.event_time   = w_grid + vev_pkg::IDLE_INTERVAL;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// File: hdl/volume_envelope_unit.sv
// Volume envelope of a sound channel. Every request beat on i_req (envelope
// step, register write, trigger, stop, power-up init) yields exactly one beat
// on o_res carrying the volume, the next envelope step time (all ones when
// stopped) and the DAC-off flag, in request order. A request is registered on
// acceptance and its result is registered in the output register when that
// register is free or being read. One request is taken every cycle while the
// output is not stalled; the rate is set by the single compute stage
// that updates the envelope state, whose longest path is the 32-bit grid
// alignment and timestamp add of a trigger. While a result waits on o_res,
// one more request is still taken into the input register.
module volume_envelope_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vev_req_if.sink      i_req,
    vev_res_if.source    o_res
);

    logic            r_in_valid;
    vev_pkg::t_req   r_in;
    vev_pkg::t_state r_state;
    logic            r_out_valid;
    vev_pkg::t_res   r_out;

    vev_pkg::t_state n_state;
    logic            w_adv;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || w_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    vev_calc u_calc (
        .i_state (r_state),
        .i_req   (r_in),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.volume_level  <= 4'd0;
            r_state.event_time    <= vev_pkg::STOPPED_TIME;
            r_state.envelope_reg  <= 8'd0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            // commit state only when the result has room to move
            if (w_adv && r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (w_adv && r_in_valid) begin
            r_out.volume          <= n_state.volume_level;
            r_out.next_event_time <= n_state.event_time;
            r_out.dac_off         <= (n_state.envelope_reg[7:3] == 5'd0);
        end
    end

endmodule

// File: hdl/vev_checker.sv
module vev_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic [2:0]    i_in_req_type,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input vev_pkg::t_res i_out_data
);

    // no result beat right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // input side must not wait while the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request stalled with empty output");

    // a stop that moves through unstalled reports a stopped timestamp
    a_stop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_req_type == vev_pkg::REQ_STOP)
        ##1 i_out_ready |=>
        (i_out_valid && i_out_data.next_event_time == vev_pkg::STOPPED_TIME))
        else $error("stop did not report stopped timestamp");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result beat changed");

endmodule

bind volume_envelope_unit vev_checker u_vev_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_in_req_type (i_req.data.req_type),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_data    (o_res.data)
);

// File: bench/volume_envelope_unit_tb.sv
`timescale 1ns / 100ps

module volume_envelope_unit_tb;

    localparam int CLOCK_LIMIT    = 200000;
    localparam int TAIL_BEATS     = 200;
    localparam int LONG_HOLD      = 60;
    localparam int HOLD_AT_RESULT = 300;
    localparam int RANDOM_BEATS   = 1150;
    localparam int DRAIN_EVERY    = 250;

    // request codes the block leaves undefined
    localparam logic [2:0] REQ_UNDEF_LO = 3'd5;
    localparam logic [2:0] REQ_UNDEF_HI = 3'd7;

    typedef struct packed {
        vev_pkg::t_req req;
        logic          drain;
    } t_queued_beat;

    logic i_clk;
    logic i_rst_n;

    vev_req_if req_if ();
    vev_res_if res_if ();

    volume_envelope_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_queued_beat  beat_backlog[$];
    vev_pkg::t_res envelope_due[$];

    int n_total;
    int beats_taken;
    int results_seen;
    int gap_left;
    int hold_left;
    int errors;
    int clk_cycles;
    bit long_hold_done;
    bit drain_next;

    // envelope state as the block should hold it
    logic [3:0]  mdl_volume;
    logic [31:0] mdl_time;
    logic [7:0]  mdl_env;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] grid_align(logic [31:0] cc);
        return cc - ((cc - vev_pkg::GRID_OFFSET) & vev_pkg::GRID_MASK);
    endfunction

    function automatic vev_pkg::t_res update_envelope(vev_pkg::t_req rq);
        logic [2:0]    period;
        logic [3:0]    mult;
        vev_pkg::t_res rs;
        period = mdl_env[2:0];
        case (rq.req_type)
            vev_pkg::REQ_STEP: begin
                if (period == 3'd0) begin
                    mdl_time = mdl_time + vev_pkg::IDLE_INTERVAL;
                end else if (mdl_env[3] ? (mdl_volume == 4'hF) : (mdl_volume == 4'h0)) begin
                    mdl_time = vev_pkg::STOPPED_TIME;
                end else begin
                    mdl_volume = mdl_env[3] ? mdl_volume + 4'd1 : mdl_volume - 4'd1;
                    mdl_time   = mdl_time + ({29'd0, period} << 15);
                end
            end
            vev_pkg::REQ_WRITE: begin
                if (period == 3'd0 && mdl_time != vev_pkg::STOPPED_TIME)
                    mdl_volume = mdl_volume + 4'd1;
                else if (!mdl_env[3])
                    mdl_volume = mdl_volume + 4'd2;
                if (mdl_env[3] != rq.reg_value[3])
                    mdl_volume = 4'd0 - mdl_volume;
                mdl_env = rq.reg_value;
            end
            vev_pkg::REQ_TRIGGER: begin
                mult = (period == 3'd0) ? 4'd8 : {1'b0, period};
                if (rq.cycle_count[14:12] == 3'd0)
                    mult = mult + 4'd1;
                mdl_time   = grid_align(rq.cycle_count) + ({28'd0, mult} << 15);
                mdl_volume = mdl_env[7:4];
            end
            vev_pkg::REQ_STOP: begin
                mdl_time = vev_pkg::STOPPED_TIME;
            end
            vev_pkg::REQ_INIT: begin
                mdl_volume = 4'd0;
                if (rq.is_channel1) begin
                    mdl_env  = vev_pkg::CH1_ENV_INIT;
                    mdl_time = vev_pkg::STOPPED_TIME;
                end else begin
                    mdl_env  = 8'd0;
                    mdl_time = grid_align(rq.cycle_count) + vev_pkg::IDLE_INTERVAL;
                end
            end
            default: begin
            end
        endcase
        rs.volume          = mdl_volume;
        rs.next_event_time = mdl_time;
        rs.dac_off         = (mdl_env[7:3] == 5'd0);
        return rs;
    endfunction

    function automatic vev_pkg::t_req mk_req(logic [2:0] kind, logic [7:0] rv,
                                             logic [31:0] cc, logic ch1);
        vev_pkg::t_req rq;
        rq.req_type    = kind;
        rq.reg_value   = rv;
        rq.cycle_count = cc;
        rq.is_channel1 = ch1;
        return rq;
    endfunction

    function automatic vev_pkg::t_req rand_req(logic [2:0] kind);
        vev_pkg::t_req rq;
        rq = mk_req(kind, 8'($urandom), $urandom, 1'($urandom));
        case ($urandom_range(0, 3))
            0: rq.cycle_count[14:12] = 3'd0;
            1: rq.cycle_count[31:16] = 16'hFFFF;
            default: begin
            end
        endcase
        return rq;
    endfunction

    task automatic queue_beat(vev_pkg::t_req rq);
        t_queued_beat qb;
        qb.req     = rq;
        qb.drain   = drain_next;
        drain_next = 1'b0;
        beat_backlog.push_back(qb);
        if (beat_backlog.size() % DRAIN_EVERY == 0)
            drain_next = 1'b1;
    endtask

    function automatic logic [2:0] rand_kind();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return vev_pkg::REQ_STEP;
        if (pick < 65) return vev_pkg::REQ_WRITE;
        if (pick < 80) return vev_pkg::REQ_TRIGGER;
        if (pick < 87) return vev_pkg::REQ_STOP;
        if (pick < 95) return vev_pkg::REQ_INIT;
        return 3'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
    endfunction

    always @(posedge i_clk) begin : beat_driver
        t_queued_beat nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_if.ready) begin
            // hold the beat until the block takes it
        end else begin
            if (req_if.valid) begin
                envelope_due.push_back(update_envelope(req_if.data));
                beats_taken++;
                if (beat_backlog.size() >= TAIL_BEATS && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 4);
            end
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (beat_backlog.size() == 0 ||
                         (beat_backlog[0].drain && envelope_due.size() != 0)) begin
                req_if.valid <= 1'b0;
            end else begin
                nxt = beat_backlog.pop_front();
                req_if.valid <= 1'b1;
                req_if.data  <= nxt.req;
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        vev_pkg::t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (envelope_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat: volume %0d time %h dac_off %0b", $time,
                             res_if.data.volume, res_if.data.next_event_time,
                             res_if.data.dac_off);
                end else begin
                    want = envelope_due.pop_front();
                    if (res_if.data.volume !== want.volume) begin
                        errors++;
                        $display("%0t: volume expected %0d actual %0d", $time,
                                 want.volume, res_if.data.volume);
                    end
                    if (res_if.data.next_event_time !== want.next_event_time) begin
                        errors++;
                        $display("%0t: next_event_time expected %h actual %h", $time,
                                 want.next_event_time, res_if.data.next_event_time);
                    end
                    if (res_if.data.dac_off !== want.dac_off) begin
                        errors++;
                        $display("%0t: dac_off expected %0b actual %0b", $time,
                                 want.dac_off, res_if.data.dac_off);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= HOLD_AT_RESULT) begin
                // stall long enough for the block to back up into its input
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                res_if.ready <= 1'b0;
            end else if (results_seen + TAIL_BEATS < n_total &&
                         $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 3);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        clk_cycles = 0;
        while (clk_cycles < CLOCK_LIMIT) begin
            @(posedge i_clk);
            clk_cycles++;
        end
        $display("volume_envelope_unit_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int steps;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        res_if.ready   = 1'b0;
        beats_taken    = 0;
        results_seen   = 0;
        gap_left       = 0;
        hold_left      = 0;
        errors         = 0;
        long_hold_done = 1'b0;
        drain_next     = 1'b0;
        mdl_volume     = 4'd0;
        mdl_time       = vev_pkg::STOPPED_TIME;
        mdl_env        = 8'd0;

        queue_beat(mk_req(vev_pkg::REQ_INIT, 8'hA5, 32'h0000_0000, 1'b1));
        queue_beat(mk_req(vev_pkg::REQ_STEP, 8'h5A, 32'hFFFF_FFFF, 1'b0)); // step down past zero
        queue_beat(mk_req(REQ_UNDEF_HI, 8'hFF, 32'hFFFF_FFFF, 1'b1));
        queue_beat(mk_req(vev_pkg::REQ_INIT, 8'h00, 32'hFFFF_FFFF, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_STEP, 8'h00, 32'h0, 1'b0));         // zero period
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'h00, 32'h0, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'hF8, 32'h0, 1'b0));        // direction flips
        queue_beat(mk_req(vev_pkg::REQ_TRIGGER, 8'h00, 32'h0000_0000, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'hF9, 32'h0, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_TRIGGER, 8'h00, 32'h0000_7000, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_STEP, 8'h00, 32'h0, 1'b0));         // step up past 15
        queue_beat(mk_req(vev_pkg::REQ_STEP, 8'h00, 32'h0, 1'b0));         // step while stopped
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'h08, 32'h0, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_TRIGGER, 8'h00, 32'hFFFF_FFFF, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_STOP, 8'hFF, 32'h1234_5678, 1'b1));
        queue_beat(mk_req(vev_pkg::REQ_STEP, 8'h00, 32'h0, 1'b0));         // add wraps
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'h01, 32'h0, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_TRIGGER, 8'h00, 32'h0000_1000, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_STEP, 8'h00, 32'h0, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'h00, 32'h0, 1'b0));
        queue_beat(mk_req(REQ_UNDEF_LO, 8'h3C, 32'h8000_0001, 1'b1));
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'hFF, 32'h0, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_TRIGGER, 8'h00, 32'h0000_8FFF, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_STEP, 8'h00, 32'h0, 1'b0));
        queue_beat(mk_req(vev_pkg::REQ_WRITE, 8'h07, 32'h0, 1'b0));
        drain_next = 1'b1;

        while (beat_backlog.size() < RANDOM_BEATS) begin
            if ($urandom_range(0, 9) < 8) begin
                // write, trigger, then a run of steps toward the volume limits
                queue_beat(rand_req(vev_pkg::REQ_WRITE));
                queue_beat(rand_req(vev_pkg::REQ_TRIGGER));
                steps = $urandom_range(2, 18);
                repeat (steps) queue_beat(rand_req(vev_pkg::REQ_STEP));
                case ($urandom_range(0, 3))
                    0: queue_beat(rand_req(vev_pkg::REQ_WRITE));
                    1: queue_beat(rand_req(vev_pkg::REQ_STOP));
                    default: begin
                    end
                endcase
            end else begin
                queue_beat(rand_req(rand_kind()));
            end
        end
        n_total = beat_backlog.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < n_total) @(posedge i_clk);
        while (envelope_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0 && envelope_due.size() == 0) begin
            $display("volume_envelope_unit_tb: clean");
        end else begin
            $display("volume_envelope_unit_tb: errors");
        end
        $finish;
    end

endmodule
